// ===== design/dqr_pkg.sv =====
package dqr_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int ITEM_BITS_DEF = 32;

  localparam int OP_W     = 3;
  localparam int HANDLE_W = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE_AT  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOPOS = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] item;
    logic [POS_W-1:0]    position;
  } in_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] out_item;
    logic                out_valid;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    logic [HANDLE_W-1:0] first_item;
    logic [HANDLE_W-1:0] last_item;
  } out_t;

endpackage

// ===== design/dqr_in_if.sv =====
interface dqr_in_if;
  logic          valid;
  logic          ready;
  dqr_pkg::in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/dqr_out_if.sv =====
interface dqr_out_if;
  logic          valid;
  logic          ready;
  dqr_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/dqr_store.sv =====
module dqr_store #(
  parameter int DEPTH     = dqr_pkg::DEPTH_DEF,
  parameter int ITEM_BITS = dqr_pkg::ITEM_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  dqr_pkg::in_t  cmd,
  output dqr_pkg::out_t res
);

  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int CMP_W  = (FILL_W > dqr_pkg::POS_W) ? FILL_W : dqr_pkg::POS_W;
  localparam int HW     = dqr_pkg::HANDLE_W;

  logic [ITEM_BITS-1:0] slots_r   [DEPTH];
  logic [ITEM_BITS-1:0] slots_nxt [DEPTH];
  logic [FILL_W-1:0]    fill_r;
  logic [FILL_W-1:0]    fill_nxt;

  logic [CMP_W-1:0]     fill_c;
  logic [CMP_W-1:0]     pos_c;
  logic [CMP_W-1:0]     rm_idx;
  logic [CMP_W-1:0]     new_fill_c;
  logic                 full;
  logic                 empty;
  logic                 do_pf;
  logic                 do_pb;
  logic                 do_rm;
  logic [dqr_pkg::STATUS_W-1:0] status;

  logic [ITEM_BITS+HW-1:0] item_wide;
  logic [ITEM_BITS-1:0]    item_s;
  logic [ITEM_BITS-1:0]    got;
  logic [ITEM_BITS-1:0]    last;
  logic [ITEM_BITS+HW-1:0] got_wide;
  logic [ITEM_BITS+HW-1:0] first_wide;
  logic [ITEM_BITS+HW-1:0] last_wide;

  assign item_wide = {{ITEM_BITS{1'b0}}, cmd.item};
  assign item_s    = item_wide[ITEM_BITS-1:0];

  assign fill_c = CMP_W'(fill_r);
  assign pos_c  = CMP_W'(cmd.position);
  assign full   = (fill_c == CMP_W'(DEPTH));
  assign empty  = (fill_r == '0);

  always_comb begin
    do_pf  = 1'b0;
    do_pb  = 1'b0;
    do_rm  = 1'b0;
    rm_idx = '0;
    status = dqr_pkg::ST_OK;
    case (cmd.op)
      dqr_pkg::OP_PUSH_FRONT: begin
        if (full) status = dqr_pkg::ST_FULL;
        else      do_pf  = 1'b1;
      end
      dqr_pkg::OP_PUSH_BACK: begin
        if (full) status = dqr_pkg::ST_FULL;
        else      do_pb  = 1'b1;
      end
      dqr_pkg::OP_POP_FRONT: begin
        if (empty) status = dqr_pkg::ST_EMPTY;
        else       do_rm  = 1'b1;
      end
      dqr_pkg::OP_POP_BACK: begin
        if (empty) begin
          status = dqr_pkg::ST_EMPTY;
        end else begin
          do_rm  = 1'b1;
          rm_idx = fill_c - CMP_W'(1);
        end
      end
      dqr_pkg::OP_REMOVE_AT: begin
        if (empty) begin
          status = dqr_pkg::ST_EMPTY;
        end else if (pos_c == '0 || pos_c > fill_c) begin
          status = dqr_pkg::ST_NOPOS;
        end else begin
          do_rm  = 1'b1;
          rm_idx = pos_c - CMP_W'(1);
        end
      end
      default: status = dqr_pkg::ST_OK;
    endcase
  end

  // Each cell picks its next value: a front push shifts everything back, a back push
  // writes the first free cell, a removal closes up the cells behind the removed one.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [ITEM_BITS-1:0] cell_nxt;

    always_comb begin
      cell_nxt = slots_r[k];
      if (do_pf) begin
        if (k == 0) cell_nxt = item_s;
        else        cell_nxt = slots_r[(k == 0) ? 0 : k - 1];
      end
      if (do_pb && fill_c == CMP_W'(k)) cell_nxt = item_s;
      if (do_rm && CMP_W'(k) >= rm_idx && k < DEPTH - 1) begin
        cell_nxt = slots_r[(k < DEPTH - 1) ? k + 1 : k];
      end
    end

    assign slots_nxt[k] = cell_nxt;

    always_ff @(posedge clk) begin
      if (accept) slots_r[k] <= cell_nxt;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (do_pf || do_pb) fill_nxt = fill_r + FILL_W'(1);
    else if (do_rm)     fill_nxt = fill_r - FILL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  assign new_fill_c = CMP_W'(fill_nxt);

  // One-hot selections of the removed cell and of the new last cell.
  always_comb begin
    got  = '0;
    last = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (do_rm && rm_idx == CMP_W'(k)) got = got | slots_r[k];
      if (new_fill_c != '0 && new_fill_c - CMP_W'(1) == CMP_W'(k)) begin
        last = last | slots_nxt[k];
      end
    end
  end

  assign got_wide   = {{HW{1'b0}}, got};
  assign first_wide = {{HW{1'b0}}, slots_nxt[0]};
  assign last_wide  = {{HW{1'b0}}, last};

  always_comb begin
    res.out_item   = got_wide[HW-1:0];
    res.out_valid  = do_rm;
    res.status     = status;
    res.count      = dqr_pkg::COUNT_W'(fill_nxt);
    res.is_empty   = (fill_nxt == '0);
    res.first_item = (fill_nxt == '0) ? '0 : first_wide[HW-1:0];
    res.last_item  = last_wide[HW-1:0];
  end

endmodule

// ===== design/deque_with_positional_removal_unit.sv =====
// Bounded double-ended list of handles with removal at a 1-based position.
// Each accepted beat carries one operation (push front, push back, pop front,
// pop back, remove at position) and yields exactly one result beat, which
// reports the removed handle, a status code, the count and the first and
// last handles after the operation. One beat is accepted every cycle while the
// output register is empty or its result is being taken, and its result appears
// in the output register on the next cycle; the whole update of the shift array
// of DEPTH cells is worked out combinationally. The input stays ready while a result
// waits, as long as that result is taken in the same cycle.
module deque_with_positional_removal_unit #(
  parameter int DEPTH     = dqr_pkg::DEPTH_DEF,
  parameter int ITEM_BITS = dqr_pkg::ITEM_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  dqr_in_if.sink    in_if,
  dqr_out_if.source out_if
);

  logic          accept;
  dqr_pkg::out_t res;
  logic          out_vld_r;
  dqr_pkg::out_t out_data_r;

  assign in_if.ready = !out_vld_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  dqr_store #(
    .DEPTH     (DEPTH),
    .ITEM_BITS (ITEM_BITS)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .cmd    (in_if.data),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (accept) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data_r <= res;
  end

  assign out_if.valid = out_vld_r;
  assign out_if.data  = out_data_r;

  a_removed_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.data.out_valid |-> out_if.data.status == dqr_pkg::ST_OK)
    else $error("removed handle reported with a failure status");

  a_empty_ends : assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.data.is_empty |->
      out_if.data.first_item == '0 && out_if.data.last_item == '0)
    else $error("empty list reports nonzero end handles");

  a_single_ends : assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.data.count == dqr_pkg::COUNT_W'(1) |->
      out_if.data.first_item == out_if.data.last_item)
    else $error("single-item list reports different end handles");

  a_accept_result : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_if.valid)
    else $error("accepted beat produced no result");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import dqr_pkg::*;

  typedef enum int {TREND_GROW, TREND_SHRINK, TREND_MIXED} trend_t;

  // Keeps its own copy of the list, works out the result of every accepted
  // beat and holds those results until the block delivers them.
  class deque_tracker;
    logic [HANDLE_W-1:0] held [DEPTH_DEF];
    int unsigned held_count;
    out_t awaited [$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned removals;
    int unsigned refused_pushes;
    int unsigned empty_pops;
    int unsigned bad_positions;
    int unsigned full_hits;

    function new();
      held_count = 0;
      mismatches = 0;
      results_seen = 0;
      removals = 0;
      refused_pushes = 0;
      empty_pops = 0;
      bad_positions = 0;
      full_hits = 0;
    endfunction

    function logic [HANDLE_W-1:0] extract(int unsigned idx);
      logic [HANDLE_W-1:0] v;
      v = held[idx];
      for (int unsigned k = idx; k + 1 < held_count; k++) held[k] = held[k + 1];
      held_count--;
      return v;
    endfunction

    function void apply_op(in_t beat);
      out_t r;
      r = '0;
      case (beat.op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (held_count >= DEPTH_DEF) begin
            r.status = ST_FULL;
          end else if (beat.op == OP_PUSH_FRONT) begin
            for (int unsigned k = held_count; k > 0; k--) held[k] = held[k - 1];
            held[0] = beat.item;
            held_count++;
          end else begin
            held[held_count] = beat.item;
            held_count++;
          end
        end
        OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT: begin
          if (held_count == 0) begin
            r.status = ST_EMPTY;
          end else if (beat.op == OP_POP_FRONT) begin
            r.out_item = extract(0);
            r.out_valid = 1'b1;
          end else if (beat.op == OP_POP_BACK) begin
            r.out_item = extract(held_count - 1);
            r.out_valid = 1'b1;
          end else if (beat.position == 0 || beat.position > held_count) begin
            r.status = ST_NOPOS;
          end else begin
            r.out_item = extract(beat.position - 1);
            r.out_valid = 1'b1;
          end
        end
        default: ;
      endcase
      r.count = COUNT_W'(held_count);
      r.is_empty = (held_count == 0);
      r.first_item = (held_count != 0) ? held[0] : '0;
      r.last_item = (held_count != 0) ? held[held_count - 1] : '0;
      if (r.out_valid) removals++;
      if (r.status == ST_FULL) refused_pushes++;
      if (r.status == ST_EMPTY) empty_pops++;
      if (r.status == ST_NOPOS) bad_positions++;
      if (held_count == DEPTH_DEF) full_hits++;
      awaited.push_back(r);
    endfunction

    function void compare_field(string name, logic [HANDLE_W-1:0] exp_v,
                                logic [HANDLE_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void match_result(out_t got);
      out_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        $display("%0t: result with none awaited, expected nothing, actual %0h", $time, got);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      compare_field("out_item", want.out_item, got.out_item);
      compare_field("out_valid", HANDLE_W'(want.out_valid), HANDLE_W'(got.out_valid));
      compare_field("status", HANDLE_W'(want.status), HANDLE_W'(got.status));
      compare_field("count", HANDLE_W'(want.count), HANDLE_W'(got.count));
      compare_field("is_empty", HANDLE_W'(want.is_empty), HANDLE_W'(got.is_empty));
      compare_field("first_item", want.first_item, got.first_item);
      compare_field("last_item", want.last_item, got.last_item);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit steady_run;
  deque_tracker tracker;

  dqr_in_if  in_ch ();
  dqr_out_if out_ch ();

  deque_with_positional_removal_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("deque_with_positional_removal_unit test failed");
    $finish;
  end

  // The receiver stalls at random except during the steady stretch.
  initial begin
    out_ch.ready = 1'b0;
    forever @(negedge clk) out_ch.ready <= steady_run || ($urandom_range(0, 99) >= 16);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) tracker.apply_op(in_ch.data);
      if (out_ch.valid && out_ch.ready) tracker.match_result(out_ch.data);
    end
  end

  function automatic in_t make_beat(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] item,
                                    logic [POS_W-1:0] position);
    in_t b;
    b.op = op;
    b.item = item;
    b.position = position;
    return b;
  endfunction

  function automatic in_t random_beat(trend_t trend);
    in_t b;
    int r;
    int push_pct;
    int unsigned span;
    b.item = $urandom;
    r = $urandom_range(0, 19);
    if (r == 0) b.item = '0;
    else if (r == 1) b.item = '1;
    // Aim most removals at positions that are actually present.
    span = (tracker.held_count > 0) ? tracker.held_count : 1;
    if ($urandom_range(0, 99) < 70) b.position = POS_W'($urandom_range(1, span));
    else b.position = POS_W'($urandom_range(1, DEPTH_DEF));
    push_pct = (trend == TREND_GROW) ? 65 : (trend == TREND_SHRINK) ? 25 : 45;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      b.op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    end else if (r < 94) begin
      case ($urandom_range(0, 3))
        0: b.op = OP_POP_FRONT;
        1: b.op = OP_POP_BACK;
        default: b.op = OP_REMOVE_AT;
      endcase
    end else if (r < 97) begin
      b.op = OP_REMOVE_AT;
      b.position = $urandom_range(0, 1) ? '0 : POS_W'($urandom_range(DEPTH_DEF + 1, 31));
    end else begin
      b.op = OP_REMOVE_AT + OP_W'($urandom_range(1, 3));
      b.position = POS_W'($urandom);
    end
    return b;
  endfunction

  task automatic send_beat(input in_t beat);
    while (!steady_run && $urandom_range(0, 99) < 16) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= beat;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int unsigned real_ops;
    trend_t trend;
    in_t beat;

    tracker = new();
    steady_run = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty list: an empty list wins over a bad position.
    send_beat(make_beat(OP_POP_FRONT, '1, '0));
    send_beat(make_beat(OP_POP_BACK, '0, '1));
    send_beat(make_beat(OP_REMOVE_AT, '0, '0));
    send_beat(make_beat(OP_REMOVE_AT, '0, '1));
    // Fill to capacity from both ends, then push against a full list.
    for (int i = 0; i < DEPTH_DEF; i++) begin
      send_beat(make_beat((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                          (i == 0) ? '0 : (i == 1) ? '1 : HANDLE_W'($urandom), '0));
    end
    send_beat(make_beat(OP_PUSH_FRONT, 32'h1234_5678, '0));
    send_beat(make_beat(OP_PUSH_BACK, 32'h8765_4321, '0));
    send_beat(make_beat(OP_REMOVE_AT, '0, '0));
    send_beat(make_beat(OP_REMOVE_AT, '0, POS_W'(DEPTH_DEF + 1)));
    send_beat(make_beat(OP_REMOVE_AT, '0, POS_W'(DEPTH_DEF)));
    send_beat(make_beat(OP_REMOVE_AT, '0, 5'd1));
    send_beat(make_beat(OP_REMOVE_AT, '1, 5'd7));
    for (int i = 1; i <= 3; i++) begin
      send_beat(make_beat(OP_REMOVE_AT + OP_W'(i), '1, '1));
    end

    real_ops = 0;
    trend = TREND_GROW;
    for (int n = 0; real_ops < 1420; n++) begin
      if (n % 30 == 0) trend = trend_t'($urandom_range(0, 2));
      steady_run = (n >= 600 && n < 900);
      beat = random_beat(trend);
      if (beat.op <= OP_REMOVE_AT) real_ops++;
      send_beat(beat);
    end
    steady_run = 1'b0;
    in_ch.valid <= 1'b0;

    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d results: %0d handles removed, %0d full-list refusals,",
             tracker.results_seen, tracker.removals, tracker.refused_pushes);
    $display("%0d pops on an empty list, %0d absent positions, %0d results at capacity.",
             tracker.empty_pops, tracker.bad_positions, tracker.full_hits);
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
      $display("deque_with_positional_removal_unit test passed");
    end else begin
      $display("deque_with_positional_removal_unit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dqr_pkg.sv
design/dqr_in_if.sv
design/dqr_out_if.sv
design/dqr_store.sv
design/deque_with_positional_removal_unit.sv
verif/testbench.sv
